// ===== hdl/mpq_pkg.sv =====
package mpq_pkg;

   localparam int CAPACITY = 1024;
   localparam int KEY_W    = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   // child index 2*pos+2 must fit without wrapping
   localparam int CHILD_W  = ADDR_W + 2;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      OP_INSERT  = 1'b0,
      OP_EXTRACT = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_CHECK,
      S_UP_CMP,
      S_DN_ROOT,
      S_DN_LAST,
      S_DN_CHECK,
      S_DN_LEFT,
      S_DN_RIGHT,
      S_DN_CMP,
      S_DONE
   } state_type;

   typedef struct packed {
      op_type             mode;
      logic [KEY_W-1:0]   key;
   } cmd_type;

   typedef struct packed {
      logic [KEY_W-1:0]   min_key;
      status_type         status;
   } res_type;

endpackage

// ===== hdl/mpq_ram.sv =====
module mpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mpq_core.sv =====
module mpq_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  mpq_pkg::cmd_type  cmd,
   output logic              cmd_ready,
   output logic              res_valid,
   output mpq_pkg::res_type  res,
   input  logic              res_ready
);

   mpq_pkg::state_type               state_ff, state_in;
   logic [mpq_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic [mpq_pkg::ADDR_W-1:0]       pos_ff, pos_in;
   logic [mpq_pkg::ADDR_W-1:0]       idx_ff, idx_in;
   logic [mpq_pkg::KEY_W-1:0]        val_ff, val_in;
   logic [mpq_pkg::KEY_W-1:0]        cand_ff, cand_in;
   logic [mpq_pkg::KEY_W-1:0]        min_key_ff, min_key_in;
   mpq_pkg::status_type              status_ff, status_in;

   logic                             wr_en;
   logic [mpq_pkg::ADDR_W-1:0]       wr_addr;
   logic [mpq_pkg::KEY_W-1:0]        wr_data;
   logic                             rd_en;
   logic [mpq_pkg::ADDR_W-1:0]       rd_addr;
   logic [mpq_pkg::KEY_W-1:0]        rd_data;

   logic [mpq_pkg::KEY_W-1:0]        cmp_a, cmp_b;
   logic                             cmp_lt;
   logic [mpq_pkg::ADDR_W-1:0]       parent;
   logic [mpq_pkg::CHILD_W-1:0]      left, right, count_ext;

   mpq_ram #(
      .WIDTH (mpq_pkg::KEY_W),
      .DEPTH (mpq_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // index arithmetic for one heap level
   assign parent    = (pos_ff - mpq_pkg::ADDR_W'(1)) >> 1;
   assign left      = mpq_pkg::CHILD_W'({pos_ff, 1'b1});
   assign right     = left + mpq_pkg::CHILD_W'(1);
   assign count_ext = mpq_pkg::CHILD_W'(count_ff);

   // shared signed comparator: cmp_a < cmp_b
   always_comb begin
      unique case (state_ff)
         mpq_pkg::S_DN_RIGHT: begin
            cmp_a = rd_data;
            cmp_b = cand_ff;
         end
         mpq_pkg::S_DN_CMP: begin
            cmp_a = cand_ff;
            cmp_b = val_ff;
         end
         default: begin
            cmp_a = val_ff;
            cmp_b = rd_data;
         end
      endcase
   end

   assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

   // sequencer: next state, store accesses, result
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      val_in     = val_ff;
      cand_in    = cand_ff;
      min_key_in = min_key_ff;
      status_in  = status_ff;
      wr_en      = 1'b0;
      wr_addr    = pos_ff;
      wr_data    = val_ff;
      rd_en      = 1'b0;
      rd_addr    = parent;
      cmd_ready  = 1'b0;
      res_valid  = 1'b0;

      unique case (state_ff)
         mpq_pkg::S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               min_key_in = '0;
               status_in  = mpq_pkg::ST_OK;
               if (cmd.mode == mpq_pkg::OP_INSERT) begin
                  if (count_ff == mpq_pkg::COUNT_W'(mpq_pkg::CAPACITY)) begin
                     status_in = mpq_pkg::ST_FULL;
                     state_in  = mpq_pkg::S_DONE;
                  end else begin
                     pos_in   = count_ff[mpq_pkg::ADDR_W-1:0];
                     val_in   = cmd.key;
                     count_in = count_ff + mpq_pkg::COUNT_W'(1);
                     state_in = mpq_pkg::S_UP_CHECK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = mpq_pkg::ST_EMPTY;
                     state_in  = mpq_pkg::S_DONE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     count_in = count_ff - mpq_pkg::COUNT_W'(1);
                     state_in = mpq_pkg::S_DN_ROOT;
                  end
               end
            end
         end
         mpq_pkg::S_UP_CHECK: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = mpq_pkg::S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = parent;
               idx_in   = parent;
               state_in = mpq_pkg::S_UP_CMP;
            end
         end
         mpq_pkg::S_UP_CMP: begin
            // move parent down, or settle the new key here
            wr_en = 1'b1;
            if (cmp_lt) begin
               wr_data  = rd_data;
               pos_in   = idx_ff;
               state_in = mpq_pkg::S_UP_CHECK;
            end else begin
               state_in = mpq_pkg::S_DONE;
            end
         end
         mpq_pkg::S_DN_ROOT: begin
            min_key_in = rd_data;
            if (count_ff == '0) begin
               state_in = mpq_pkg::S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = count_ff[mpq_pkg::ADDR_W-1:0];
               state_in = mpq_pkg::S_DN_LAST;
            end
         end
         mpq_pkg::S_DN_LAST: begin
            val_in   = rd_data;
            pos_in   = '0;
            state_in = mpq_pkg::S_DN_CHECK;
         end
         mpq_pkg::S_DN_CHECK: begin
            if (left >= count_ext) begin
               wr_en    = 1'b1;
               state_in = mpq_pkg::S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = left[mpq_pkg::ADDR_W-1:0];
               state_in = mpq_pkg::S_DN_LEFT;
            end
         end
         mpq_pkg::S_DN_LEFT: begin
            cand_in = rd_data;
            idx_in  = left[mpq_pkg::ADDR_W-1:0];
            if (right < count_ext) begin
               rd_en    = 1'b1;
               rd_addr  = right[mpq_pkg::ADDR_W-1:0];
               state_in = mpq_pkg::S_DN_RIGHT;
            end else begin
               state_in = mpq_pkg::S_DN_CMP;
            end
         end
         mpq_pkg::S_DN_RIGHT: begin
            // take the right child only when strictly smaller
            if (cmp_lt) begin
               cand_in = rd_data;
               idx_in  = right[mpq_pkg::ADDR_W-1:0];
            end
            state_in = mpq_pkg::S_DN_CMP;
         end
         mpq_pkg::S_DN_CMP: begin
            wr_en = 1'b1;
            if (cmp_lt) begin
               wr_data  = cand_ff;
               pos_in   = idx_ff;
               state_in = mpq_pkg::S_DN_CHECK;
            end else begin
               state_in = mpq_pkg::S_DONE;
            end
         end
         mpq_pkg::S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = mpq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mpq_pkg::S_IDLE;
         end
      endcase
   end

   assign res.min_key = min_key_ff;
   assign res.status  = status_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpq_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      idx_ff     <= idx_in;
      val_ff     <= val_in;
      cand_ff    <= cand_in;
      min_key_ff <= min_key_in;
      status_ff  <= status_in;
   end

endmodule

// ===== hdl/min_priority_queue.sv =====
// Channel  | Dir | Ports                   | Contents
// request  | in  | req_tvalid/tready/tdata | tdata: key; tuser: mode (0 insert, 1 extract)
// response | out | rsp_tvalid/tready/tdata | tdata: min_key; tuser: status
//
// One request at a time. An insert climbs one heap level per pass, moving the parent
// down, and writes the new key where it settles. An extract reads the root, then the
// last key, then descends one level per pass, reading both children when present; one
// that empties the queue ends after the root read. A dropped insert or an empty
// extract goes straight to the response. Reset clears the entry count and the
// sequencer state; the store needs no clearing pass. The next request is taken while
// a response waits in the output register; a stalled response holds the sequencer in
// its last step.
module min_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] key
   input  logic        req_tuser,  // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] min_key
   output logic [1:0]  rsp_tuser   // [1:0] status
);

   mpq_pkg::cmd_type     cmd;
   mpq_pkg::res_type     res;
   logic                 res_valid;
   logic                 res_ready;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_key_ff;
   mpq_pkg::status_type  rsp_status_ff;

   assign cmd.mode = mpq_pkg::op_type'(req_tuser);
   assign cmd.key  = req_tdata;

   mpq_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid),
      .cmd       (cmd),
      .cmd_ready (req_tready),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   // output register: load when empty or being drained
   assign res_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = (res_valid && res_ready) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_key_ff    <= res.min_key;
         rsp_status_ff <= res.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_key_ff;
   assign rsp_tuser  = rsp_status_ff;

   // a response never carries the unused status code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_tuser != 2'd3))
      else $error("undefined status code on response");

   // only a successful extract returns a nonzero key
   a_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != mpq_pkg::ST_OK)) |-> (rsp_key_ff == '0))
      else $error("nonzero key with failure status");

   // an accepted request keeps the sequencer busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous one in progress");

   // a finished result waits when the output register is held
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (res_valid && rsp_valid_ff && !rsp_tready) |=> res_valid)
      else $error("result dropped while output stalled");

endmodule

// ===== sim/min_priority_queue_tb.sv =====
module min_priority_queue_tb;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] key
   logic        req_tuser;   // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;   // [31:0] min_key
   logic [1:0]  rsp_tuser;   // [1:0] status

   // Keys the queue should hold, and responses still owed by the block
   logic signed [31:0]  stored_keys[$];
   mpq_pkg::res_type    owed_results[$];

   // Idle control for the sender and the receiver
   bit req_idle_on;
   bit rsp_idle_on;
   int rsp_hold_cycles;
   int rsp_stall_left;

   int error_count;
   int checked_count;
   int insert_ok_count;
   int full_count;
   int extract_ok_count;
   int empty_count;
   int peak_depth;

   min_priority_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // Mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap(bit enabled);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!enabled || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Mix full-range keys with small clustered keys, extremes and narrow values
   function automatic logic [31:0] pick_key();
      int unsigned roll;
      logic [31:0] narrow;
      roll = $urandom_range(0, 99);
      if (roll < 60) return $urandom();
      if (roll < 75) return 32'($urandom_range(0, 16)) - 32'd8;
      if (roll < 85) begin
         case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h8000_0001;
            2: return 32'h7FFF_FFFF;
            3: return 32'h7FFF_FFFE;
            4: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      narrow = $urandom() >> $urandom_range(1, 31);
      if ($urandom_range(0, 1)) narrow = ~narrow;
      return narrow;
   endfunction

   // Apply one accepted request to the queue contents and record the owed response
   task automatic predict_queue_op(input mpq_pkg::op_type op, input logic [31:0] key);
      mpq_pkg::res_type outcome;
      int               min_idx;
      outcome.min_key = '0;
      outcome.status  = mpq_pkg::ST_OK;
      if (op == mpq_pkg::OP_INSERT) begin
         if (stored_keys.size() >= mpq_pkg::CAPACITY) begin
            outcome.status = mpq_pkg::ST_FULL;
            full_count++;
         end else begin
            stored_keys.push_back(key);
            insert_ok_count++;
            if (stored_keys.size() > peak_depth) peak_depth = stored_keys.size();
         end
      end else if (stored_keys.size() == 0) begin
         outcome.status = mpq_pkg::ST_EMPTY;
         empty_count++;
      end else begin
         min_idx = 0;
         for (int i = 1; i < stored_keys.size(); i++) begin
            if (stored_keys[i] < stored_keys[min_idx]) min_idx = i;
         end
         outcome.min_key = stored_keys[min_idx];
         stored_keys.delete(min_idx);
         extract_ok_count++;
      end
      owed_results.push_back(outcome);
   endtask

   // Offer one request after a random gap and hold it until the block takes it
   task automatic send_request(input mpq_pkg::op_type op, input logic [31:0] key);
      int gap;
      gap = pick_gap(req_idle_on);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_queue_op(op, key);
   endtask

   task automatic check_response(input logic [31:0] got_key, input logic [1:0] got_status);
      mpq_pkg::res_type wanted;
      checked_count++;
      if (owed_results.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("ERROR: response with none owed: min_key %0d status %0d",
                     $signed(got_key), got_status);
         return;
      end
      wanted = owed_results.pop_front();
      if (got_key !== wanted.min_key || got_status !== wanted.status) begin
         error_count++;
         if (error_count <= 10)
            $display("ERROR: response %0d: min_key exp %0d got %0d, status exp %s got %0d",
                     checked_count, $signed(wanted.min_key), $signed(got_key),
                     wanted.status.name(), got_status);
      end
   endtask

   // Check each response transaction at the edge that accepts it
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_response(rsp_tdata, rsp_tuser);
   end

   // Drive the response ready: a requested long hold first, then random stalls
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles--;
      end else if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall_left = pick_gap(rsp_idle_on);
      end
   end

   // Empty queue, extreme keys, duplicates, then drain past empty
   task automatic test_extremes();
      send_request(mpq_pkg::OP_EXTRACT, 32'h1234_5678);
      send_request(mpq_pkg::OP_INSERT, 32'h7FFF_FFFF);
      send_request(mpq_pkg::OP_INSERT, 32'h8000_0000);
      send_request(mpq_pkg::OP_INSERT, 32'h0000_0000);
      send_request(mpq_pkg::OP_INSERT, 32'hFFFF_FFFF);
      send_request(mpq_pkg::OP_INSERT, 32'h0000_0001);
      send_request(mpq_pkg::OP_INSERT, 32'hFFFF_FFFF);
      send_request(mpq_pkg::OP_INSERT, 32'h8000_0000);
      repeat (8) send_request(mpq_pkg::OP_EXTRACT, $urandom());
      send_request(mpq_pkg::OP_INSERT, 32'd42);
      send_request(mpq_pkg::OP_INSERT, 32'd42);
      send_request(mpq_pkg::OP_EXTRACT, 32'hFFFF_FFFF);
      send_request(mpq_pkg::OP_EXTRACT, 32'h0000_0000);
      send_request(mpq_pkg::OP_EXTRACT, 32'h0000_0000);
   endtask

   // Fill to capacity behind a long receiver hold, overflow, then pull a few keys
   task automatic test_fill_overflow();
      rsp_hold_cycles = 400;
      for (int i = 0; i < 32; i++) send_request(mpq_pkg::OP_INSERT, 32'd5000 - 32'(i * 7));
      for (int i = 32; i < mpq_pkg::CAPACITY + 4; i++)
         send_request(mpq_pkg::OP_INSERT, pick_key());
      for (int i = 0; i < 32; i++) send_request(mpq_pkg::OP_EXTRACT, $urandom());
   endtask

   // Random traffic in phases with varying insert bias and idle behavior
   task automatic test_random_traffic(input int item_total);
      int              phase_left;
      int              insert_pct;
      mpq_pkg::op_type op;
      phase_left = 0;
      insert_pct = 50;
      for (int sent = 0; sent < item_total; sent++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 80);
            case ($urandom_range(0, 3))
               0: insert_pct = 25;
               1: insert_pct = 50;
               2: insert_pct = 75;
               default: insert_pct = 90;
            endcase
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         op = ($urandom_range(0, 99) < insert_pct) ? mpq_pkg::OP_INSERT : mpq_pkg::OP_EXTRACT;
         send_request(op, pick_key());
         phase_left--;
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = mpq_pkg::OP_INSERT;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_fill_overflow();
      test_random_traffic(250);

      // Release the request channel and wait for every owed response
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (owed_results.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Ran %0d inserts (%0d dropped on a full queue) and %0d extracts (%0d on empty).",
               insert_ok_count + full_count, full_count, extract_ok_count + empty_count,
               empty_count);
      $display("Checked %0d responses, peak depth %0d of %0d, %0d mismatches.",
               checked_count, peak_depth, mpq_pkg::CAPACITY, error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #24_000_000;
      $display("ERROR: timeout with %0d responses still owed", owed_results.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
